/* rtl/ptt_pkg.sv */
// Shared types, codes and constants of the periodic timer table.
package ptt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int NOW_W      = 64;
    localparam int PERIOD_W   = 32;
    localparam int REASON_W   = 8;
    localparam int CLIENT_W   = 16;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_ADD  = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;

    typedef enum logic [2:0] {
        KIND_FIRED    = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_ADDED    = 3'd2,
        KIND_DELETED  = 3'd3,
        KIND_NOTFOUND = 3'd4,
        KIND_REJECTED = 3'd5,
        KIND_FULL     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_REJ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [REASON_W-1:0] reason;
        logic [CLIENT_W-1:0] client_id;
        logic [PERIOD_W-1:0] interval;
    } in_word_t;

    typedef struct packed {
        kind_t               kind;
        logic [REASON_W-1:0] fired_reason;
        logic [CLIENT_W-1:0] fired_client;
        logic                last;
    } out_word_t;

    typedef struct packed {
        op_t                 op;
        logic [REASON_W-1:0] reason;
        logic [CLIENT_W-1:0] client;
        logic [PERIOD_W-1:0] interval;
    } cmd_t;

    typedef struct packed {
        logic [NOW_W-1:0]    expiry;
        logic [PERIOD_W-1:0] period;
        logic [REASON_W-1:0] reason;
        logic [CLIENT_W-1:0] client;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

/* rtl/ptt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ptt_front.sv */
// Front stage: accepts input words and classifies them into commands.
module ptt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptt_pkg::in_word_t s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output ptt_pkg::cmd_t     q_cmd
);

    logic          hold_valid_reg, hold_valid_next;
    ptt_pkg::cmd_t hold_cmd_reg, hold_cmd_next;
    ptt_pkg::cmd_t cls_cmd;

    // Malformed requests are turned into rejects here so the back end never
    // has to look at the raw function code.
    always_comb begin
        cls_cmd.reason   = s_data.reason;
        cls_cmd.client   = s_data.client_id;
        cls_cmd.interval = s_data.interval;
        unique case (s_data.func)
            ptt_pkg::FUNC_TICK: begin
                cls_cmd.op = ptt_pkg::OP_TICK;
            end
            ptt_pkg::FUNC_ADD: begin
                cls_cmd.op = (s_data.client_id == '0 || s_data.interval == '0) ?
                             ptt_pkg::OP_REJ : ptt_pkg::OP_ADD;
            end
            ptt_pkg::FUNC_DEL: begin
                cls_cmd.op = (s_data.client_id == '0) ? ptt_pkg::OP_REJ : ptt_pkg::OP_DEL;
            end
            default: begin
                cls_cmd.op = ptt_pkg::OP_REJ;
            end
        endcase
    end

    assign s_ready = !hold_valid_reg || q_ready;
    assign q_valid = hold_valid_reg;
    assign q_cmd   = hold_cmd_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = cls_cmd;
        end else if (q_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

/* rtl/ptt_queue.sv */
// Short command queue between the front stage and the back-end sequencer.
module ptt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptt_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ptt_pkg::cmd_t out_cmd
);

    localparam int PTR_W = (ptt_pkg::QUEUE_DEPTH > 1) ? $clog2(ptt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptt_pkg::QUEUE_DEPTH + 1);

    ptt_pkg::cmd_t    entry_reg [ptt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(ptt_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/ptt_back.sv */
// Back-end sequencer: scans the slot table per command and emits result words.
module ptt_back #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  ptt_pkg::cmd_t      q_cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output ptt_pkg::out_word_t m_data
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    ptt_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [ptt_pkg::NOW_W-1:0]        now_reg, now_next;
    logic [NUM_TIMERS-1:0]            valid_reg, valid_next;
    logic                             found_reg, found_next;
    logic [IDX_W-1:0]                 match_reg, match_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::REASON_W-1:0]     pend_reason_reg, pend_reason_next;
    logic [ptt_pkg::CLIENT_W-1:0]     pend_client_reg, pend_client_next;
    logic                             m_valid_reg, m_valid_next;
    ptt_pkg::out_word_t               m_word_reg, m_word_next;

    ptt_pkg::slot_t                   rd_slot;
    ptt_pkg::slot_t                   wr_slot;
    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    logic [IDX_W-1:0]                 ram_raddr;
    logic                             out_free;
    logic                             push_out;
    ptt_pkg::out_word_t               out_word;
    logic                             key_hit;
    logic                             fire_hit;
    logic                             is_last_idx;
    logic                             advance;
    logic [IDX_W-1:0]                 idx_inc;
    logic                             free_any;
    logic [IDX_W-1:0]                 free_idx;

    ptt_ram #(
        .WIDTH (ptt_pkg::SLOT_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_slot),
        .raddr (ram_raddr),
        .rdata (rd_slot)
    );

    assign out_free    = !m_valid_reg || m_ready;
    assign is_last_idx = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign idx_inc     = is_last_idx ? '0 : idx_reg + IDX_W'(1);
    assign key_hit     = valid_reg[idx_reg] && (rd_slot.reason == cmd_reg.reason) &&
                         (rd_slot.client == cmd_reg.client);
    assign fire_hit    = valid_reg[idx_reg] && (rd_slot.expiry == now_reg);
    assign q_ready     = (state_reg == ST_IDLE);

    // Lowest free slot.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        valid_next       = valid_reg;
        found_next       = found_reg;
        match_next       = match_reg;
        pend_valid_next  = pend_valid_reg;
        pend_reason_next = pend_reason_reg;
        pend_client_next = pend_client_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_raddr        = '0;
        wr_slot          = rd_slot;
        advance          = 1'b1;
        push_out         = 1'b0;
        out_word         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next        = q_cmd;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    if (q_cmd.op == ptt_pkg::OP_REJ) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                        if (q_cmd.op == ptt_pkg::OP_TICK) begin
                            now_next = now_reg + ptt_pkg::NOW_W'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (cmd_reg.op == ptt_pkg::OP_TICK) begin
                    if (fire_hit) begin
                        if (pend_valid_reg && !out_free) begin
                            advance = 1'b0;
                        end else begin
                            ram_we        = 1'b1;
                            ram_waddr     = idx_reg;
                            wr_slot.expiry = rd_slot.expiry +
                                             ptt_pkg::NOW_W'(rd_slot.period);
                            if (pend_valid_reg) begin
                                push_out              = 1'b1;
                                out_word.kind         = ptt_pkg::KIND_FIRED;
                                out_word.fired_reason = pend_reason_reg;
                                out_word.fired_client = pend_client_reg;
                                out_word.last         = 1'b0;
                            end
                            pend_valid_next  = 1'b1;
                            pend_reason_next = rd_slot.reason;
                            pend_client_next = rd_slot.client;
                        end
                    end
                end else if (key_hit && !found_reg) begin
                    found_next = 1'b1;
                    match_next = idx_reg;
                end
                ram_raddr = advance ? idx_inc : idx_reg;
                if (advance) begin
                    idx_next = idx_inc;
                    if (is_last_idx) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    push_out              = 1'b1;
                    state_next            = ST_IDLE;
                    out_word.last         = 1'b1;
                    out_word.fired_reason = cmd_reg.reason;
                    out_word.fired_client = cmd_reg.client;
                    wr_slot.expiry        = now_reg + ptt_pkg::NOW_W'(cmd_reg.interval);
                    wr_slot.period        = cmd_reg.interval;
                    wr_slot.reason        = cmd_reg.reason;
                    wr_slot.client        = cmd_reg.client;
                    unique case (cmd_reg.op)
                        ptt_pkg::OP_TICK: begin
                            if (pend_valid_reg) begin
                                out_word.kind         = ptt_pkg::KIND_FIRED;
                                out_word.fired_reason = pend_reason_reg;
                                out_word.fired_client = pend_client_reg;
                            end else begin
                                out_word.kind         = ptt_pkg::KIND_NONE;
                                out_word.fired_reason = '0;
                                out_word.fired_client = '0;
                            end
                        end
                        ptt_pkg::OP_ADD: begin
                            if (found_reg || free_any) begin
                                ram_we                = 1'b1;
                                ram_waddr             = found_reg ? match_reg : free_idx;
                                valid_next[ram_waddr] = 1'b1;
                                out_word.kind         = ptt_pkg::KIND_ADDED;
                            end else begin
                                out_word.kind = ptt_pkg::KIND_FULL;
                            end
                        end
                        ptt_pkg::OP_DEL: begin
                            if (found_reg) begin
                                valid_next[match_reg] = 1'b0;
                                out_word.kind         = ptt_pkg::KIND_DELETED;
                            end else begin
                                out_word.kind = ptt_pkg::KIND_NOTFOUND;
                            end
                        end
                        default: begin
                            out_word.kind = ptt_pkg::KIND_REJECTED;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (push_out) begin
            m_valid_next = 1'b1;
            m_word_next  = out_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        idx_reg         <= idx_next;
        cmd_reg         <= cmd_next;
        match_reg       <= match_next;
        pend_reason_reg <= pend_reason_next;
        pend_client_reg <= pend_client_next;
        m_word_reg      <= m_word_next;
    end

endmodule

/* rtl/periodic_timer_table.sv */
// Top level of the periodic timer table: front stage, command queue and back end.
// A tick, add or delete passes from the back end's idle state, which takes it from the
// queue, through a scan of every slot over the slot RAM's read port to the finish state;
// a reject goes from idle straight to finish. While an output word is held, a firing
// tick's scan stalls.
// Reset (aresetn low at an edge) empties the queue, clears the tick counter and valid bits.
module periodic_timer_table #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ptt_pkg::out_word_t m_data
);

    // Front stage to queue: a classified command per word.
    logic          fq_valid;
    logic          fq_ready;
    ptt_pkg::cmd_t fq_cmd;

    // Queue to back end.
    logic          qb_valid;
    logic          qb_ready;
    ptt_pkg::cmd_t qb_cmd;

    // The front stage registers each accepted word and folds the reject rules
    // (zero client, zero interval, unknown function) into the command opcode.
    ptt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_cmd   (fq_cmd)
    );

    // The queue lets the front keep accepting words while the back end scans.
    ptt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // The back end owns the tick counter, the valid bits and the slot RAM. A tick
    // holds the latest fired timer back by one so that the final word of the tick
    // can carry the last flag.
    ptt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_cmd   (qb_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the periodic timer table: directed table, random segments.
`timescale 1ns / 100ps

module tb;
    import ptt_pkg::*;

    // Size of the timer table under test; the block runs with its default.
    localparam int SLOTS = NUM_TIMERS_DEF;

    // Rough number of input words for the whole run.
    localparam int TOTAL_WORDS = 360;

    // A tick scans every slot and may hold each fired word for a full receiver stall.
    // The longest correct stretch without a handshake is a sender gap plus one back-end
    // pass plus one receiver stall.
    localparam int IDLE_LIMIT = 2000;

    // Cycles to watch for stray words once the last expected word has arrived.
    localparam int SETTLE_CYCLES = 60;

    // One row of the directed stimulus. Rows marked typed carry their single result
    // word written out by hand; the others are checked against the table predictor.
    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t want;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    periodic_timer_table i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow copy of the timer table and its tick counter.
    // ------------------------------------------------------------------------
    logic [NOW_W-1:0]    tick_count;
    logic                live         [SLOTS];
    logic [NOW_W-1:0]    due_at       [SLOTS];
    logic [PERIOD_W-1:0] every        [SLOTS];
    logic [REASON_W-1:0] owner_reason [SLOTS];
    logic [CLIENT_W-1:0] owner_client [SLOTS];

    // Result words caused by the word just accepted, and all words still owed by the block.
    out_word_t step_results   [$];
    out_word_t expected_words [$];

    // Run statistics and the failure count.
    int words_sent     = 0;
    int results_seen   = 0;
    int ticks_sent     = 0;
    int firing_ticks   = 0;
    int most_fired     = 0;
    int full_rejects   = 0;
    int fault_count    = 0;

    // Counters of remaining no-wait draws, one per side, to get bursts at full rate.
    int send_calm = 0;
    int recv_calm = 0;

    function automatic out_word_t make_result(kind_t k, logic [REASON_W-1:0] r,
                                              logic [CLIENT_W-1:0] c);
        out_word_t o;
        o.kind         = k;
        o.fired_reason = r;
        o.fired_client = c;
        o.last         = 1'b0;
        return o;
    endfunction

    function automatic int key_slot(logic [REASON_W-1:0] r, logic [CLIENT_W-1:0] c);
        for (int i = 0; i < SLOTS; i++) begin
            if (live[i] && owner_reason[i] == r && owner_client[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // Applies one accepted word to the shadow table and leaves its result words in
    // step_results, the final one flagged with last.
    function automatic void advance_timer_table(in_word_t w);
        out_word_t r;
        int        s;
        step_results.delete();
        case (w.func)
            FUNC_TICK: begin
                tick_count += 64'd1;
                ticks_sent++;
                // Every live timer due now fires once and moves one period ahead,
                // so it cannot match again within the same tick.
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i] && due_at[i] == tick_count) begin
                        due_at[i] += {32'd0, every[i]};
                        step_results.push_back(make_result(KIND_FIRED, owner_reason[i],
                                                           owner_client[i]));
                    end
                end
                if (step_results.size() == 0) begin
                    step_results.push_back(make_result(KIND_NONE, '0, '0));
                end else begin
                    firing_ticks++;
                    if (step_results.size() > most_fired) begin
                        most_fired = step_results.size();
                    end
                end
            end
            FUNC_ADD: begin
                if (w.client_id == '0 || w.interval == '0) begin
                    step_results.push_back(make_result(KIND_REJECTED, w.reason, w.client_id));
                end else begin
                    // Same key replaces in place; otherwise take the lowest free slot.
                    s = key_slot(w.reason, w.client_id);
                    if (s < 0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!live[i]) begin
                                s = i;
                                break;
                            end
                        end
                    end
                    if (s < 0) begin
                        full_rejects++;
                        step_results.push_back(make_result(KIND_FULL, w.reason, w.client_id));
                    end else begin
                        live[s]         = 1'b1;
                        owner_reason[s] = w.reason;
                        owner_client[s] = w.client_id;
                        every[s]        = w.interval;
                        due_at[s]       = tick_count + {32'd0, w.interval};
                        step_results.push_back(make_result(KIND_ADDED, w.reason, w.client_id));
                    end
                end
            end
            FUNC_DEL: begin
                if (w.client_id == '0) begin
                    step_results.push_back(make_result(KIND_REJECTED, w.reason, w.client_id));
                end else begin
                    s = key_slot(w.reason, w.client_id);
                    if (s < 0) begin
                        step_results.push_back(make_result(KIND_NOTFOUND, w.reason,
                                                           w.client_id));
                    end else begin
                        live[s] = 1'b0;
                        step_results.push_back(make_result(KIND_DELETED, w.reason,
                                                           w.client_id));
                    end
                end
            end
            default: begin
                step_results.push_back(make_result(KIND_REJECTED, w.reason, w.client_id));
            end
        endcase
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
    endfunction

    // Wait length for the next word on one side: mostly drawn uniformly at random, with
    // occasional stretches of back-to-back words.
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Valid is raised once per word and held until the handshake;
    // when the next word follows without a gap, valid simply stays high so that
    // no step ever carries two assignments to it.
    // ------------------------------------------------------------------------
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // Accepted at this edge: update the shadow table and queue what is owed.
        words_sent++;
        advance_timer_table(w);
        if (typed) begin
            expected_words.push_back(want);
        end else begin
            foreach (step_results[k]) begin
                expected_words.push_back(step_results[k]);
            end
        end
    endtask

    task automatic send_checked(input in_word_t w);
        send_word(w, 1'b0, '0);
    endtask

    function automatic in_word_t build_word(logic [1:0] f, logic [REASON_W-1:0] r,
                                            logic [CLIENT_W-1:0] c, logic [PERIOD_W-1:0] iv);
        in_word_t w;
        w.func      = f;
        w.reason    = r;
        w.client_id = c;
        w.interval  = iv;
        return w;
    endfunction

    function automatic dir_row_t dir_row(logic [1:0] f, logic [REASON_W-1:0] r,
                                         logic [CLIENT_W-1:0] c, logic [PERIOD_W-1:0] iv,
                                         logic typed, kind_t k);
        dir_row_t d;
        d.word      = build_word(f, r, c, iv);
        d.typed     = typed;
        d.want      = make_result(k, r, c);
        d.want.last = 1'b1;
        return d;
    endfunction

    // Add, delete and tick traffic around a small set of keys. Two reasons and two
    // clients give four keys that share one field pairwise, so lookups must match
    // on both halves of the key.
    task automatic churn_keys(input int count);
        logic [REASON_W-1:0] pool_reason [2];
        logic [CLIENT_W-1:0] pool_client [2];
        logic [REASON_W-1:0] r;
        logic [CLIENT_W-1:0] c;
        logic [PERIOD_W-1:0] iv;
        int                  roll;
        for (int i = 0; i < 2; i++) begin
            pool_reason[i] = REASON_W'($urandom);
            pool_client[i] = CLIENT_W'($urandom_range(1, 65535));
        end
        for (int n = 0; n < count; n++) begin
            r    = pool_reason[$urandom_range(0, 1)];
            c    = pool_client[$urandom_range(0, 1)];
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_checked(build_word(FUNC_TICK, REASON_W'($urandom), CLIENT_W'($urandom),
                                        $urandom));
            end else if (roll < 80) begin
                // Mostly short periods so timers fire often; now and then a long one.
                if ($urandom_range(0, 9) == 0) begin
                    iv = $urandom;
                end else begin
                    iv = PERIOD_W'($urandom_range(1, 6));
                end
                send_checked(build_word(FUNC_ADD, r, c, iv));
            end else begin
                send_checked(build_word(FUNC_DEL, r, c, $urandom));
            end
        end
    endtask

    // Empties the table, fills every slot with timers of one period, pushes a few
    // adds against the full table, ticks until all of them fire together, and then
    // deletes a random part of them again.
    task automatic fill_and_fire();
        logic [PERIOD_W-1:0] p;
        int                  tries;
        for (int i = 0; i < SLOTS; i++) begin
            if (live[i]) begin
                send_checked(build_word(FUNC_DEL, owner_reason[i], owner_client[i], $urandom));
            end
        end
        p     = PERIOD_W'($urandom_range(1, 4));
        tries = 0;
        while (live_count() < SLOTS && tries < 4 * SLOTS) begin
            send_checked(build_word(FUNC_ADD, REASON_W'($urandom),
                                    CLIENT_W'($urandom_range(1, 65535)), p));
            tries++;
        end
        repeat ($urandom_range(1, 3)) begin
            send_checked(build_word(FUNC_ADD, REASON_W'($urandom),
                                    CLIENT_W'($urandom_range(1, 65535)), $urandom));
        end
        repeat (p) begin
            send_checked(build_word(FUNC_TICK, '0, '0, '0));
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (live[i] && $urandom_range(0, 1) == 1) begin
                send_checked(build_word(FUNC_DEL, owner_reason[i], owner_client[i], '0));
            end
        end
    endtask

    // Words with every field drawn over its full range, including the unused
    // function code and the zero client, to check the reject paths.
    task automatic send_jumble(input int count);
        logic [CLIENT_W-1:0] c;
        for (int n = 0; n < count; n++) begin
            c = ($urandom_range(0, 3) == 0) ? '0 : CLIENT_W'($urandom);
            send_checked(build_word(2'($urandom_range(0, 3)), REASON_W'($urandom), c,
                                    ($urandom_range(0, 5) == 0) ? '0 : $urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, the directed table, then random segments.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t dir_table [$];
        int       roll;

        tick_count = '0;
        for (int i = 0; i < SLOTS; i++) begin
            live[i] = 1'b0;
        end

        // Typed rows are single-word results whose value is plain from the input:
        // the empty tick after reset, every reject path, adds and deletes with
        // extreme keys and intervals. Ticks after live timers go to the predictor.
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, KIND_NONE));
        dir_table.push_back(dir_row(FUNC_ADD, 8'hFF, 16'h0000, 32'd5, 1'b1, KIND_REJECTED));
        dir_table.push_back(dir_row(FUNC_ADD, 8'h00, 16'h0001, 32'd0, 1'b1, KIND_REJECTED));
        dir_table.push_back(dir_row(FUNC_DEL, 8'h5A, 16'h0000, 32'd0, 1'b1, KIND_REJECTED));
        dir_table.push_back(dir_row(OP_REJ, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                    KIND_REJECTED));
        dir_table.push_back(dir_row(FUNC_DEL, 8'h00, 16'hFFFF, 32'd0, 1'b1, KIND_NOTFOUND));
        dir_table.push_back(dir_row(FUNC_ADD, 8'h00, 16'hFFFF, 32'd1, 1'b1, KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_ADD, 8'hFF, 16'h0001, 32'hFFFF_FFFF, 1'b1,
                                    KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_ADD, 8'h03, 16'h0007, 32'd2, 1'b1, KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        // Same key again: replaced in its own slot with a new period.
        dir_table.push_back(dir_row(FUNC_ADD, 8'h03, 16'h0007, 32'd3, 1'b1, KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        dir_table.push_back(dir_row(FUNC_DEL, 8'h00, 16'hFFFF, 32'd0, 1'b1, KIND_DELETED));
        dir_table.push_back(dir_row(FUNC_DEL, 8'h00, 16'hFFFF, 32'd0, 1'b1, KIND_NOTFOUND));
        // The freed lowest slot is taken again.
        dir_table.push_back(dir_row(FUNC_ADD, 8'h00, 16'hFFFF, 32'h8000_0000, 1'b1,
                                    KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        dir_table.push_back(dir_row(FUNC_ADD, 8'hA5, 16'h5A5A, 32'd1, 1'b1, KIND_ADDED));
        dir_table.push_back(dir_row(FUNC_TICK, 8'h00, 16'h0000, 32'd0, 1'b0, KIND_FIRED));
        // A delete ignores the interval field.
        dir_table.push_back(dir_row(FUNC_DEL, 8'hFF, 16'h0001, 32'hFFFF_FFFF, 1'b1,
                                    KIND_DELETED));
        dir_table.push_back(dir_row(OP_REJ, 8'h00, 16'h0000, 32'd0, 1'b1, KIND_REJECTED));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[k]) begin
            send_word(dir_table[k].word, dir_table[k].typed, dir_table[k].want);
        end

        // The first random segment always fills the table so that a full table and
        // a tick firing every slot are seen in each run.
        fill_and_fire();
        while (words_sent < TOTAL_WORDS) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                churn_keys($urandom_range(8, 20));
            end else if (roll < 8) begin
                fill_and_fire();
            end else begin
                send_jumble($urandom_range(4, 10));
            end
        end
        s_valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d words (%0d ticks, %0d of them firing, up to %0d timers at once),",
                 words_sent, ticks_sent, firing_ticks, most_fired);
        $display("checked %0d result words, %0d adds refused on a full table.",
                 results_seen, full_rejects);
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready stalls at random, and each accepted word is compared
    // field by field with the oldest word owed by the predictor.
    // ------------------------------------------------------------------------
    initial begin : result_check
        out_word_t got;
        out_word_t want;
        int        pause;
        wait (aresetn === 1'b1);
        forever begin
            pause = draw_wait(recv_calm);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = m_data;
            results_seen++;
            if (expected_words.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("Unexpected result word %0d: kind %0d reason %h client %h last %b",
                             results_seen, got.kind, got.fired_reason, got.fired_client,
                             got.last);
                end
            end else begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.fired_reason !== want.fired_reason ||
                    got.fired_client !== want.fired_client || got.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("Result word %0d differs: kind %0d/%0d reason %h/%h",
                                 results_seen, want.kind, got.kind, want.fired_reason,
                                 got.fired_reason);
                        $display("    client %h/%h last %b/%b (expected/actual)",
                                 want.fired_client, got.fired_client, want.last, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake on either side restarts the count. A run that sits
    // without a handshake until the count reaches IDLE_LIMIT has hung.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("No handshake for %0d cycles with %0d result words outstanding.",
                     IDLE_LIMIT, expected_words.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* periodic_timer_table.f */
rtl/ptt_pkg.sv
rtl/ptt_ram.sv
rtl/ptt_front.sv
rtl/ptt_queue.sv
rtl/ptt_back.sv
rtl/periodic_timer_table.sv
tb/tb.sv
